// File: rtl/baro_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// baro_pkg
// Shared constants, register indexes and helpers for the barometer
// compensation pipeline.
// ----------------------------------------------------------------------------
package baro_pkg;

  // configuration register indexes
  typedef enum logic [7:0] {
    CFG_TEMP_COEF  = 8'd0,
    CFG_PRES_LOW   = 8'd1,
    CFG_PRES_HIGH  = 8'd2,
    CFG_PRES_NINE  = 8'd3
  } cfg_index_t;

  localparam int CFG_DATA_W   = 64;
  localparam int CFG_INDEX_W  = 8;
  localparam int DIV_STEPS    = 32;
  localparam int PRE_STAGES   = 10;
  localparam int POST_STAGES  = 3;
  localparam int PIPE_STAGES  = PRE_STAGES + DIV_STEPS + POST_STAGES;

  localparam logic signed [31:0] FINE_OFFSET = 32'sd64000;
  localparam logic signed [31:0] PRES_BASE   = 32'sd1048576;
  localparam logic signed [31:0] VAR1_BASE   = 32'sd32768;
  localparam logic signed [31:0] TEMP_ROUND  = 32'sd128;
  localparam logic signed [31:0] PRES_SCALE  = 32'sd3125;

  // signed divide by 2^k, truncating toward zero
  function automatic logic signed [31:0] sdiv_p2(input logic signed [31:0] x,
                                                 input int unsigned k);
    logic signed [31:0] bias;
    bias = x[31] ? signed'((32'd1 << k) - 32'd1) : 32'sd0;
    return (x + bias) >>> k;
  endfunction

  // 16-bit coefficient slices widened to 32 bits
  function automatic logic signed [31:0] sx16(input logic [15:0] v);
    return signed'({{16{v[15]}}, v});
  endfunction

  function automatic logic signed [31:0] zx16(input logic [15:0] v);
    return signed'({16'd0, v});
  endfunction

endpackage

// File: rtl/barometer_raw_to_compensated.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// barometer_raw_to_compensated
// Pipelined 32-bit integer compensation of raw barometer records.
// ----------------------------------------------------------------------------
// Takes one six-byte raw record per cycle and returns compensated temperature
// (0.01 degC) and pressure (Pa): ten stages of multiply and shift arithmetic,
// a 32-stage restoring divider that retires one quotient bit per stage, and
// three stages of final pressure correction. The whole pipe advances together
// and holds while a result waits at the output, so a sustained rate of one
// item per cycle is kept whenever the sink is ready. With a zero pressure
// divisor the unfinished pressure is returned with pressure_valid low. The
// user must write coefficients only while the pipe is empty (not enforced).
module barometer_raw_to_compensated (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              cfg_write,
  input  logic [baro_pkg::CFG_INDEX_W-1:0]  cfg_index,
  input  logic [baro_pkg::CFG_DATA_W-1:0]   cfg_data,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic [7:0]                        pressure_msb,
  input  logic [7:0]                        pressure_lsb,
  input  logic [7:0]                        pressure_xlsb,
  input  logic [7:0]                        temperature_msb,
  input  logic [7:0]                        temperature_lsb,
  input  logic [7:0]                        temperature_xlsb,
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic signed [31:0]                temperature_centi,
  output logic [31:0]                       pressure_pa,
  output logic                              pressure_valid
);
  import baro_pkg::*;

  // configuration registers
  logic [47:0] temp_coef;
  logic [63:0] pres_low;
  logic [63:0] pres_high;
  logic [15:0] pres_nine;

  always_ff @(posedge clk) begin
    if (rst) begin
      temp_coef <= '0;
      pres_low  <= '0;
      pres_high <= '0;
      pres_nine <= '0;
    end else if (cfg_write) begin
      case (cfg_index)
        CFG_TEMP_COEF: temp_coef <= cfg_data[47:0];
        CFG_PRES_LOW:  pres_low  <= cfg_data;
        CFG_PRES_HIGH: pres_high <= cfg_data;
        CFG_PRES_NINE: pres_nine <= cfg_data[15:0];
        default: ;
      endcase
    end
  end

  logic signed [31:0] t1, t2, t3, p1, p2, p3, p4, p5, p6, p7, p8, p9;
  assign t1 = zx16(temp_coef[15:0]);
  assign t2 = sx16(temp_coef[31:16]);
  assign t3 = sx16(temp_coef[47:32]);
  assign p1 = zx16(pres_low[15:0]);
  assign p2 = sx16(pres_low[31:16]);
  assign p3 = sx16(pres_low[47:32]);
  assign p4 = sx16(pres_low[63:48]);
  assign p5 = sx16(pres_high[15:0]);
  assign p6 = sx16(pres_high[31:16]);
  assign p7 = sx16(pres_high[47:32]);
  assign p8 = sx16(pres_high[63:48]);
  assign p9 = sx16(pres_nine);

  // pipe control: every stage moves together unless the output is stalled
  logic                   adv;
  logic [PIPE_STAGES-1:0] vld;
  assign adv       = !(vld[PIPE_STAGES-1] && !out_ready);
  assign in_ready  = adv;
  assign out_valid = vld[PIPE_STAGES-1];

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (adv) begin
      vld <= {vld[PIPE_STAGES-2:0], in_valid};
    end
  end

  // stage 1: unpack and temperature differences
  logic signed [31:0] s1_x1, s1_d;
  logic [19:0]        s1_rawp;
  logic [19:0]        raw_t;
  assign raw_t = {temperature_msb, temperature_lsb, temperature_xlsb[7:4]};

  always_ff @(posedge clk) begin
    if (adv) begin
      s1_rawp <= {pressure_msb, pressure_lsb, pressure_xlsb[7:4]};
      s1_x1   <= signed'({15'd0, raw_t[19:3]}) - (t1 <<< 1);
      s1_d    <= signed'({16'd0, raw_t[19:4]}) - t1;
    end
  end

  // stage 2: temperature products
  logic signed [31:0] s2_m1, s2_m2;
  logic [19:0]        s2_rawp;
  always_ff @(posedge clk) begin
    if (adv) begin
      s2_m1   <= 32'(s1_x1 * t2);
      s2_m2   <= 32'(s1_d * s1_d);
      s2_rawp <= s1_rawp;
    end
  end

  // stage 3: second order temperature term
  logic signed [31:0] s3_a, s3_m3;
  logic [19:0]        s3_rawp;
  always_ff @(posedge clk) begin
    if (adv) begin
      s3_a    <= sdiv_p2(s2_m1, 11);
      s3_m3   <= 32'(sdiv_p2(s2_m2, 12) * t3);
      s3_rawp <= s2_rawp;
    end
  end

  // stage 4: fine temperature
  logic signed [31:0] s4_fine;
  logic [19:0]        s4_rawp;
  always_ff @(posedge clk) begin
    if (adv) begin
      s4_fine <= s3_a + sdiv_p2(s3_m3, 14);
      s4_rawp <= s3_rawp;
    end
  end

  // stage 5: temperature result and pressure offset
  logic signed [31:0] s5_temp, s5_pa;
  logic [19:0]        s5_rawp;
  always_ff @(posedge clk) begin
    if (adv) begin
      s5_temp <= sdiv_p2(32'(s4_fine * 32'sd5) + TEMP_ROUND, 8);
      s5_pa   <= sdiv_p2(s4_fine, 1) - FINE_OFFSET;
      s5_rawp <= s4_rawp;
    end
  end

  // stage 6: first pressure products
  logic signed [31:0] s6_temp, s6_sq, s6_ap5, s6_p2a;
  logic [19:0]        s6_rawp;
  logic signed [31:0] q6;
  assign q6 = sdiv_p2(s5_pa, 2);
  always_ff @(posedge clk) begin
    if (adv) begin
      s6_temp <= s5_temp;
      s6_sq   <= 32'(q6 * q6);
      s6_ap5  <= 32'(s5_pa * p5);
      s6_p2a  <= 32'(p2 * s5_pa);
      s6_rawp <= s5_rawp;
    end
  end

  // stage 7: squared term products
  logic signed [31:0] s7_temp, s7_b6, s7_m3p, s7_ap5, s7_p2a;
  logic [19:0]        s7_rawp;
  always_ff @(posedge clk) begin
    if (adv) begin
      s7_temp <= s6_temp;
      s7_b6   <= 32'(sdiv_p2(s6_sq, 11) * p6);
      s7_m3p  <= 32'(p3 * sdiv_p2(s6_sq, 13));
      s7_ap5  <= s6_ap5;
      s7_p2a  <= s6_p2a;
      s7_rawp <= s6_rawp;
    end
  end

  // stage 8: offset and scale terms
  logic signed [31:0] s8_temp, s8_b, s8_aa;
  logic [19:0]        s8_rawp;
  always_ff @(posedge clk) begin
    if (adv) begin
      s8_temp <= s7_temp;
      s8_b    <= sdiv_p2(s7_b6 + (s7_ap5 <<< 1), 2) + (p4 <<< 16);
      s8_aa   <= sdiv_p2(sdiv_p2(s7_m3p, 3) + sdiv_p2(s7_p2a, 1), 18);
      s8_rawp <= s7_rawp;
    end
  end

  // stage 9: divisor product and unfinished pressure
  logic signed [31:0] s9_temp, s9_var1, s9_pres;
  logic signed [31:0] base9;
  assign base9 = (PRES_BASE - signed'({12'd0, s8_rawp})) - sdiv_p2(s8_b, 12);
  always_ff @(posedge clk) begin
    if (adv) begin
      s9_temp <= s8_temp;
      s9_var1 <= 32'((VAR1_BASE + s8_aa) * p1);
      s9_pres <= 32'(base9 * PRES_SCALE);
    end
  end

  // stage 10 and divider: restoring division, one quotient bit per stage
  logic [31:0]        dr   [0:DIV_STEPS];
  logic [31:0]        dn   [0:DIV_STEPS];
  logic [31:0]        dq   [0:DIV_STEPS];
  logic [31:0]        dd   [0:DIV_STEPS];
  logic signed [31:0] dtmp [0:DIV_STEPS];
  logic [31:0]        dpre [0:DIV_STEPS];
  logic               dhi  [0:DIV_STEPS];
  logic               dnz  [0:DIV_STEPS];
  logic [31:0]        den10;
  assign den10 = unsigned'(sdiv_p2(s9_var1, 15));

  always_ff @(posedge clk) begin
    if (adv) begin
      dr[0]   <= '0;
      dq[0]   <= '0;
      dn[0]   <= s9_pres[31] ? unsigned'(s9_pres) : unsigned'(s9_pres) << 1;
      dd[0]   <= den10;
      dtmp[0] <= s9_temp;
      dpre[0] <= unsigned'(s9_pres);
      dhi[0]  <= s9_pres[31];
      dnz[0]  <= den10 != 32'd0;
    end
  end

  for (genvar k = 0; k < DIV_STEPS; k++) begin : g_div
    logic [32:0] trial;
    logic [32:0] diff;
    assign trial = {dr[k], dn[k][31]};
    assign diff  = trial - {1'b0, dd[k]};
    always_ff @(posedge clk) begin
      if (adv) begin
        dr[k+1]   <= diff[32] ? trial[31:0] : diff[31:0];
        dq[k+1]   <= {dq[k][30:0], !diff[32]};
        dn[k+1]   <= dn[k] << 1;
        dd[k+1]   <= dd[k];
        dtmp[k+1] <= dtmp[k];
        dpre[k+1] <= dpre[k];
        dhi[k+1]  <= dhi[k];
        dnz[k+1]  <= dnz[k];
      end
    end
  end

  // post stage 1: quotient fixup and correction products
  logic [31:0]        q_pres;
  logic [28:0]        e_val;
  assign q_pres = dhi[DIV_STEPS] ? {dq[DIV_STEPS][30:0], 1'b0} : dq[DIV_STEPS];
  assign e_val  = q_pres[31:3];

  logic signed [31:0] c1_temp, c1_m8;
  logic [31:0]        c1_pres, c1_ee, c1_raw;
  logic               c1_nz;
  always_ff @(posedge clk) begin
    if (adv) begin
      c1_temp <= dtmp[DIV_STEPS];
      c1_pres <= q_pres;
      c1_raw  <= dpre[DIV_STEPS];
      c1_nz   <= dnz[DIV_STEPS];
      c1_ee   <= 32'({3'd0, e_val} * {3'd0, e_val});
      c1_m8   <= 32'(signed'({2'd0, q_pres[31:2]}) * p8);
    end
  end

  // post stage 2: p9 product and p8 term
  logic signed [31:0] c2_temp, c2_mp9, c2_c2;
  logic [31:0]        c2_pres, c2_raw;
  logic               c2_nz;
  always_ff @(posedge clk) begin
    if (adv) begin
      c2_temp <= c1_temp;
      c2_pres <= c1_pres;
      c2_raw  <= c1_raw;
      c2_nz   <= c1_nz;
      c2_mp9  <= 32'(p9 * signed'({13'd0, c1_ee[31:13]}));
      c2_c2   <= sdiv_p2(c1_m8, 13);
    end
  end

  // post stage 3: final correction into the output register
  logic signed [31:0] corr;
  assign corr = sdiv_p2(sdiv_p2(c2_mp9, 12) + c2_c2 + p7, 4);
  always_ff @(posedge clk) begin
    if (adv) begin
      temperature_centi <= c2_temp;
      pressure_pa       <= c2_nz ? c2_pres + unsigned'(corr) : c2_raw;
      pressure_valid    <= c2_nz;
    end
  end

  // checks
  a_reset_empty: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("result valid right after reset");
  a_hold_result: assert property (@(posedge clk) disable iff (rst)
      out_valid && !out_ready |=> out_valid && $stable(pressure_pa)
      && $stable(temperature_centi) && $stable(pressure_valid))
    else $error("stalled result changed");
  a_zero_div: assert property (@(posedge clk) disable iff (rst)
      adv && vld[PRE_STAGES-1] && den10 == 32'd0 |=> !dnz[0])
    else $error("zero divisor not flagged");

endmodule
